// File: design/qwma_pkg.sv
// Shared constants, request codes and control types for the middle-access queue.
package qwma_pkg;

  // Default sizing of the queue.
  localparam int unsigned QWMA_CAPACITY   = 32;
  localparam int unsigned QWMA_DATA_WIDTH = 32;

  // Fixed field widths of the request and result channels.
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned COUNT_W = 6;

  // Request kinds.
  localparam logic [ACT_W-1:0] ACT_APPEND      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ_MIDDLE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE_MID  = 3'd4;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic lookup;    // issue the memory reads for the request
    logic execute;   // update the queue and load the result register
  } qwma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } qwma_stat_t;

endpackage

// File: design/qwma_ctrl.sv
// Controller state machine that steps each request through capture, lookup and update.
module qwma_ctrl
  import qwma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  qwma_stat_t stat,
  output qwma_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // A new request is taken only while no other one is in flight.
  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        // Hold here until the result register is free.
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/qwma_dp.sv
// Datapath: linked slot memories, free-slot stack, queue pointers and result register.
module qwma_dp
  import qwma_pkg::*;
#(
  parameter int unsigned CAPACITY   = QWMA_CAPACITY,
  parameter int unsigned DATA_WIDTH = QWMA_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qwma_cmd_t                 cmd,
  output qwma_stat_t                stat,
  input  logic [ACT_W-1:0]          in_action,
  input  logic signed [VALUE_W-1:0] in_push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [STS_W-1:0]          out_status,
  output logic [COUNT_W-1:0]        out_entry_count
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int unsigned OCW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Slot memories and the stack of returned slots.
  logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0]     prev_mem [CAPACITY];
  logic [SLOT_W-1:0]     next_mem [CAPACITY];
  logic [SLOT_W-1:0]     stk_mem  [CAPACITY];

  // Registered read data.
  logic signed [DATA_WIDTH-1:0] val_rd_r;
  logic [SLOT_W-1:0]            prev_rd_r;
  logic [SLOT_W-1:0]            next_rd_r;
  logic [SLOT_W-1:0]            stk_rd_r;

  // Request registers.
  logic [ACT_W-1:0]          act_r;
  logic signed [VALUE_W-1:0] pv_r;

  // Queue pointers and counts.
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic [CNT_W-1:0]  stk_cnt_r, stk_cnt_nxt;

  // Result register.
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [STS_W-1:0]          res_sts_r, res_sts_nxt;
  logic [COUNT_W-1:0]        res_cnt_r, res_cnt_nxt;

  // Memory write requests.
  logic                  val_we;
  logic [SLOT_W-1:0]     val_wa;
  logic [DATA_WIDTH-1:0] val_wd;
  logic                  prev_we;
  logic [SLOT_W-1:0]     prev_wa;
  logic [SLOT_W-1:0]     prev_wd;
  logic                  next_we;
  logic [SLOT_W-1:0]     next_wa;
  logic [SLOT_W-1:0]     next_wd;
  logic                  stk_we;
  logic [SLOT_W-1:0]     stk_wa;
  logic [SLOT_W-1:0]     stk_wd;

  // Lookup addresses.
  logic [SLOT_W-1:0] val_ra;
  logic [CNT_W-1:0]  stk_top;

  // Helpers for value widths and the new slot.
  logic signed [EXT_W-1:0] pv_ext;
  logic signed [EXT_W-1:0] stored_ext;
  logic signed [EXT_W-1:0] rd_ext;
  logic [SLOT_W-1:0]       new_slot;
  logic                    empty;
  logic                    full;
  logic [OCW-1:0]          occ_out;

  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_value = res_val_r;
  assign out_status       = res_sts_r;
  assign out_entry_count  = res_cnt_r;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      pv_r  <= in_push_value;
    end
  end

  // Value to store, the stored value as read back, and the value read from memory.
  assign pv_ext     = EXT_W'(pv_r);
  assign val_wd     = pv_ext[DATA_WIDTH-1:0];
  assign stored_ext = EXT_W'($signed(val_wd));
  assign rd_ext     = EXT_W'(val_rd_r);

  assign empty   = (occ_r == '0);
  assign full    = (occ_r == CNT_W'(CAPACITY));
  assign stk_top = stk_cnt_r - CNT_W'(1);

  // Reused slot when the stack holds any, otherwise a never-used one.
  assign new_slot = (stk_cnt_r != '0) ? stk_rd_r : alloc_r[SLOT_W-1:0];

  // Value memory address: front and back reads use the end pointers.
  always_comb begin
    case (act_r)
      ACT_READ_FRONT: val_ra = head_r;
      ACT_READ_BACK:  val_ra = tail_r;
      default:        val_ra = mid_r;
    endcase
  end

  // Value memory.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (cmd.lookup) begin
      val_rd_r <= $signed(val_mem[val_ra]);
    end
  end

  // Link memories; both are looked up at the middle entry.
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd.lookup) begin
      prev_rd_r <= prev_mem[mid_r];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (cmd.lookup) begin
      next_rd_r <= next_mem[mid_r];
    end
  end

  // Stack of returned slots.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.lookup) begin
      stk_rd_r <= stk_mem[stk_top[SLOT_W-1:0]];
    end
  end

  // Queue update and result for the request in hand.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    mid_nxt     = mid_r;
    occ_nxt     = occ_r;
    alloc_nxt   = alloc_r;
    stk_cnt_nxt = stk_cnt_r;
    res_val_nxt = '0;
    res_sts_nxt = STS_OK;
    val_we      = 1'b0;
    val_wa      = new_slot;
    prev_we     = 1'b0;
    prev_wa     = new_slot;
    prev_wd     = '0;
    next_we     = 1'b0;
    next_wa     = tail_r;
    next_wd     = new_slot;
    stk_we      = 1'b0;
    stk_wa      = stk_cnt_r[SLOT_W-1:0];
    stk_wd      = mid_r;

    case (act_r)
      ACT_APPEND: begin
        if (full) begin
          res_val_nxt = pv_r;
          res_sts_nxt = STS_FULL;
        end else begin
          val_we  = 1'b1;
          prev_we = 1'b1;
          if (empty) begin
            head_nxt = new_slot;
            tail_nxt = new_slot;
            mid_nxt  = new_slot;
          end else begin
            // Chain the new slot behind the current back entry.
            prev_wd  = tail_r;
            next_we  = 1'b1;
            tail_nxt = new_slot;
          end
          occ_nxt = occ_r + CNT_W'(1);
          // The middle steps back when the count becomes odd and above one.
          if (!empty && !occ_r[0]) begin
            mid_nxt = next_rd_r;
          end
          if (stk_cnt_r != '0) begin
            stk_cnt_nxt = stk_top;
          end else begin
            alloc_nxt = alloc_r + CNT_W'(1);
          end
          res_val_nxt = stored_ext[VALUE_W-1:0];
        end
      end
      ACT_READ_MIDDLE, ACT_READ_FRONT, ACT_READ_BACK: begin
        if (empty) begin
          res_val_nxt = '1;
          res_sts_nxt = STS_EMPTY;
        end else begin
          res_val_nxt = rd_ext[VALUE_W-1:0];
        end
      end
      ACT_REMOVE_MID: begin
        if (empty) begin
          res_val_nxt = '1;
          res_sts_nxt = STS_EMPTY;
        end else begin
          if (occ_r == CNT_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
            mid_nxt  = '0;
          end else begin
            // Unlink the middle entry; the middle moves by the old count's parity.
            mid_nxt = occ_r[0] ? prev_rd_r : next_rd_r;
            prev_we = 1'b1;
            prev_wa = next_rd_r;
            prev_wd = prev_rd_r;
            if (mid_r == head_r) begin
              head_nxt = next_rd_r;
            end else begin
              next_we = 1'b1;
              next_wa = prev_rd_r;
              next_wd = next_rd_r;
            end
          end
          occ_nxt     = occ_r - CNT_W'(1);
          stk_we      = 1'b1;
          stk_cnt_nxt = stk_cnt_r + CNT_W'(1);
          res_val_nxt = rd_ext[VALUE_W-1:0];
        end
      end
      default: begin
        res_val_nxt = '0;
        res_sts_nxt = STS_OK;
      end
    endcase

    // Writes and updates only take effect on the execute step.
    if (!cmd.execute) begin
      val_we  = 1'b0;
      prev_we = 1'b0;
      next_we = 1'b0;
      stk_we  = 1'b0;
    end
  end

  assign occ_out     = OCW'(occ_nxt);
  assign res_cnt_nxt = occ_out[COUNT_W-1:0];

  // Result handshake: load on execute, drop when taken.
  always_comb begin
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_val_r <= res_val_nxt;
      res_sts_r <= res_sts_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      mid_r       <= '0;
      occ_r       <= '0;
      alloc_r     <= '0;
      stk_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.execute) begin
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        mid_r     <= mid_nxt;
        occ_r     <= occ_nxt;
        alloc_r   <= alloc_nxt;
        stk_cnt_r <= stk_cnt_nxt;
      end
    end
  end

endmodule

// File: design/queue_with_middle_access.sv
// Top level of the queue with access to its lower middle entry.
//
// Each request passes through an accept step, a lookup step for the synchronous
// reads of the value, link and free-slot memories, and an update step that
// changes the queue and loads the result register. No new request is accepted
// until the update step of the one in hand is done; the lookup step is there
// because the memory reads are registered. A finished result waits in the
// output register while the next request is accepted and looked up; the update
// step stalls only if that result has still not been taken.
// No clearing pass follows reset: slots never used are handed out by a count.
module queue_with_middle_access
  import qwma_pkg::*;
#(
  parameter int unsigned CAPACITY   = QWMA_CAPACITY,
  parameter int unsigned DATA_WIDTH = QWMA_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACT_W-1:0]          in_action,
  input  logic signed [VALUE_W-1:0] in_push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [STS_W-1:0]          out_status,
  output logic [COUNT_W-1:0]        out_entry_count
);

  qwma_cmd_t  cmd;
  qwma_stat_t stat;

  // Sequencer.
  qwma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, pointers and result register.
  qwma_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the queue with access to its lower middle entry.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qwma_pkg::*;

  // Codes five to seven carry no request kind; the block answers them with a plain count.
  localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [ACT_W-1:0] ACT_LAST_UNUSED  = 3'd7;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RANDOM_PHASES   = 20;
  localparam int PHASE_ITEMS     = 40;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STS_W-1:0]          status;
    logic [COUNT_W-1:0]        count;
  } reply_t;

  // Shadow of the queue contents plus the replies still owed by the block.
  class middle_queue_mirror;
    logic signed [VALUE_W-1:0] entries[$];
    reply_t                    replies_due[$];
    int                        mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int pending_count();
      return replies_due.size();
    endfunction

    // Apply one accepted request to the shadow and queue up the reply it earns.
    function void apply_request(logic [ACT_W-1:0] action, logic signed [VALUE_W-1:0] value);
      reply_t reply;
      int     mid;
      reply.value  = '0;
      reply.status = STS_OK;
      case (action)
        ACT_APPEND: begin
          reply.value = value;
          if (entries.size() >= QWMA_CAPACITY) begin
            reply.status = STS_FULL;
          end else begin
            entries.push_back(value);
          end
        end
        ACT_READ_MIDDLE, ACT_READ_FRONT, ACT_READ_BACK, ACT_REMOVE_MID: begin
          if (entries.size() == 0) begin
            reply.value  = -32'sd1;
            reply.status = STS_EMPTY;
          end else begin
            // The lower middle sits at index floor((count-1)/2) from the front.
            mid = (entries.size() - 1) / 2;
            case (action)
              ACT_READ_MIDDLE: reply.value = entries[mid];
              ACT_READ_FRONT:  reply.value = entries[0];
              ACT_READ_BACK:   reply.value = entries[entries.size() - 1];
              default: begin
                reply.value = entries[mid];
                entries.delete(mid);
              end
            endcase
          end
        end
        default: ;
      endcase
      reply.count = COUNT_W'(entries.size());
      replies_due.push_back(reply);
    endfunction

    function void note_mismatch(string text);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", text);
    endfunction

    // Compare one reply taken from the block with the oldest one owed.
    function void match_reply(logic signed [VALUE_W-1:0] value, logic [STS_W-1:0] status,
                              logic [COUNT_W-1:0] count);
      reply_t due;
      if (replies_due.size() == 0) begin
        note_mismatch($sformatf("unexpected reply value=%0d status=%0d count=%0d",
                                value, status, count));
        return;
      end
      due = replies_due.pop_front();
      if (value !== due.value || status !== due.status || count !== due.count) begin
        note_mismatch($sformatf(
          "expected value=%0d status=%0d count=%0d, got value=%0d status=%0d count=%0d",
          due.value, due.status, due.count, value, status, count));
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [ACT_W-1:0]          in_action;
  logic signed [VALUE_W-1:0] in_push_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_result_value;
  logic [STS_W-1:0]          out_status;
  logic [COUNT_W-1:0]        out_entry_count;

  middle_queue_mirror book;
  int   cycle_count   = 0;
  int   stall_left    = 0;
  bit   tx_idling     = 1'b1;
  bit   rx_idling     = 1'b1;
  bit   hold_off_req  = 1'b0;

  queue_with_middle_access dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** queue_with_middle_access: FAILED **");
      $finish;
    end
  end

  // Reply side: random stall bursts, plus one long hold-off when asked for.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every reply the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.match_reply(out_result_value, out_status, out_entry_count);
    end
  end

  // Offer one request, hold it until accepted, then maybe leave a gap.
  task automatic send_request(input logic [ACT_W-1:0] action,
                              input logic signed [VALUE_W-1:0] value);
    int gap;
    in_valid      <= 1'b1;
    in_action     <= action;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    book.apply_request(action, value);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering requests until every owed reply has come back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending_count() != 0);
  endtask

  initial begin
    int                        append_pct;
    int                        pick;
    logic [ACT_W-1:0]          action;
    logic signed [VALUE_W-1:0] value;

    book = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_APPEND;
    in_push_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every read and the removal on an empty queue, then the unused codes.
    send_request(ACT_READ_MIDDLE, 32'sd0);
    send_request(ACT_READ_FRONT, 32'sd0);
    send_request(ACT_READ_BACK, 32'sd0);
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_FIRST_UNUSED, -32'sd1);
    send_request(ACT_FIRST_UNUSED + 3'd1, 32'sd0);
    send_request(ACT_LAST_UNUSED, 32'sh7FFF_FFFF);

    // Extreme values in, read them back from the middle, the front and the back.
    send_request(ACT_APPEND, 32'sh8000_0000);
    send_request(ACT_APPEND, 32'sh7FFF_FFFF);
    send_request(ACT_APPEND, 32'sd0);
    send_request(ACT_APPEND, -32'sd1);
    send_request(ACT_APPEND, 32'sh5555_AAAA);
    send_request(ACT_READ_MIDDLE, 32'sd0);
    send_request(ACT_READ_FRONT, 32'sd0);
    send_request(ACT_READ_BACK, 32'sd0);
    send_request(ACT_LAST_UNUSED, 32'sd0);

    // Remove down to empty: odd and even counts, the front entry, the last entry.
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_REMOVE_MID, 32'sd0);
    send_request(ACT_READ_FRONT, 32'sd0);

    // Random phases that swing between filling to capacity and draining to empty.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0:       append_pct = 95;
        1:       append_pct = 55;
        2:       append_pct = 45;
        default: append_pct = 10;
      endcase
      rx_idling = (phase % 5 != 4) && (phase < RANDOM_PHASES - 2);
      tx_idling = rx_idling && (phase != 2);
      // Long reply hold-off while requests keep coming, so the block backs up.
      if (phase == 2) hold_off_req = 1'b1;
      // Sender pause with nothing left in flight.
      if (phase == 6) drain_replies();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        end else if (pick < 3 + append_pct * 97 / 100) begin
          action = ACT_APPEND;
        end else begin
          action = 3'($urandom_range(ACT_READ_MIDDLE, ACT_REMOVE_MID));
        end
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7FFF_FFFF;
            2:       value = 32'sd0;
            default: value = -32'sd1;
          endcase
        end else begin
          value = $urandom;
        end
        send_request(action, value);
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (book.mismatch_count == 0 && book.pending_count() == 0)
      $display("** queue_with_middle_access: PASSED **");
    else
      $display("** queue_with_middle_access: FAILED **");
    $finish;
  end

endmodule

// File: queue_with_middle_access.f
design/qwma_pkg.sv
design/qwma_ctrl.sv
design/qwma_dp.sv
design/queue_with_middle_access.sv
tb/sv/testbench.sv
